[design/c2s_pkg.sv]
// Shared types, constants and helper functions for the Cartesian to spherical converter.
// No dependencies; every other design file imports this package.
package c2s_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int ANGLE_WIDTH_DEF = 32;

	// Extra fraction bits carried on the xy-plane length before the polar CORDIC.
	localparam int FRAC_RHO = 12;

	localparam int CORDIC_W     = 64;
	localparam int TURN_W       = 32;
	localparam int CORDIC_STEPS = 32;
	localparam int NORM_STEPS   = 6;
	localparam int NORM_TOP     = 60;
	localparam int CORDIC_LAT   = 2 + NORM_STEPS + CORDIC_STEPS;

	localparam int NUM_LANES = 2;
	localparam int LANE_POL  = 0;
	localparam int LANE_AZ   = 1;

	localparam logic [TURN_W-1:0] TURN_ZERO = 32'h0000_0000;
	localparam logic [TURN_W-1:0] TURN_QTR  = 32'h4000_0000;
	localparam logic [TURN_W-1:0] TURN_HALF = 32'h8000_0000;
	localparam logic [TURN_W-1:0] TURN_3Q   = 32'hC000_0000;

	// atan(2^-i) in turns scaled by 2^32, rounded to nearest.
	localparam logic [TURN_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
	};

	typedef struct packed {
		logic [CORDIC_W-1:0] x;
		logic [CORDIC_W-1:0] y;
		logic [CORDIC_W-1:0] m;
		logic [TURN_W-1:0]   acc;
		logic                spc;
		logic [TURN_W-1:0]   fix;
	} c2s_lane_t;

	// Axis detection and folding of the left half plane onto the right one.
	function automatic c2s_lane_t c2s_pre(logic [CORDIC_W-1:0] ys, logic [CORDIC_W-1:0] xs);
		c2s_lane_t r;
		r.spc = (ys == '0) || (xs == '0);
		if (ys == '0) begin
			r.fix = xs[CORDIC_W-1] ? TURN_HALF : TURN_ZERO;
		end else begin
			r.fix = ys[CORDIC_W-1] ? TURN_3Q : TURN_QTR;
		end
		r.x   = xs[CORDIC_W-1] ? (CORDIC_W'(0) - xs) : xs;
		r.y   = xs[CORDIC_W-1] ? (CORDIC_W'(0) - ys) : ys;
		r.acc = xs[CORDIC_W-1] ? TURN_HALF : TURN_ZERO;
		r.m   = '0;
		return r;
	endfunction

	// Larger of the two magnitudes; x is already nonnegative.
	function automatic c2s_lane_t c2s_max(c2s_lane_t l);
		c2s_lane_t r;
		logic [CORDIC_W-1:0] my;
		r   = l;
		my  = l.y[CORDIC_W-1] ? (CORDIC_W'(0) - l.y) : l.y;
		r.m = (l.x > my) ? l.x : my;
		return r;
	endfunction

	// One step of the normalizing shift: shift by k when it keeps m below 2^60.
	function automatic c2s_lane_t c2s_norm(c2s_lane_t l, int k);
		c2s_lane_t r;
		r = l;
		if (l.m < (CORDIC_W'(1) << (NORM_TOP - k))) begin
			r.x = l.x << k;
			r.y = l.y << k;
			r.m = l.m << k;
		end
		return r;
	endfunction

	// One vectoring micro-rotation.
	function automatic c2s_lane_t c2s_iter(c2s_lane_t l, int sh, logic [TURN_W-1:0] ang);
		c2s_lane_t r;
		logic [CORDIC_W-1:0] dx;
		logic [CORDIC_W-1:0] dy;
		r  = l;
		dx = CORDIC_W'($signed(l.y) >>> sh);
		dy = CORDIC_W'($signed(l.x) >>> sh);
		if (l.y[CORDIC_W-1]) begin
			r.x   = l.x - dx;
			r.y   = l.y + dy;
			r.acc = l.acc - ang;
		end else begin
			r.x   = l.x + dx;
			r.y   = l.y - dy;
			r.acc = l.acc + ang;
		end
		return r;
	endfunction

endpackage

[design/c2s_point_if.sv]
// Input channel: one point as three signed coordinates with valid/ready.
// Depends on c2s_pkg for the default width.
interface c2s_point_if import c2s_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) ();
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] x_coord;
	logic signed [COORD_WIDTH-1:0] y_coord;
	logic signed [COORD_WIDTH-1:0] z_coord;

	modport source (output valid, output x_coord, output y_coord, output z_coord, input ready);
	modport sink (input valid, input x_coord, input y_coord, input z_coord, output ready);
endinterface

[design/c2s_sphere_if.sv]
// Output channel: radius, polar angle, azimuth and zero flag with valid/ready.
// Depends on c2s_pkg for the default widths.
interface c2s_sphere_if import c2s_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) ();
	logic                   valid;
	logic                   ready;
	logic [COORD_WIDTH-1:0] radius;
	logic [ANGLE_WIDTH-1:0] polar_angle;
	logic [ANGLE_WIDTH-1:0] azimuth_angle;
	logic                   zero_vector;

	modport source (output valid, output radius, output polar_angle, output azimuth_angle,
		output zero_vector, input ready);
	modport sink (input valid, input radius, input polar_angle, input azimuth_angle,
		input zero_vector, output ready);
endinterface

[design/c2s_square.sv]
// Four-stage sum of squares: magnitudes, split partial products, squares, sums.
// Depends on c2s_pkg; coordinates and zero flag travel alongside.
module c2s_square import c2s_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          vld_i,
	input  logic                          zero_i,
	input  logic signed [COORD_WIDTH-1:0] x_i,
	input  logic signed [COORD_WIDTH-1:0] y_i,
	input  logic signed [COORD_WIDTH-1:0] z_i,
	output logic                          vld_o,
	output logic                          zero_o,
	output logic signed [COORD_WIDTH-1:0] x_o,
	output logic signed [COORD_WIDTH-1:0] y_o,
	output logic signed [COORD_WIDTH-1:0] z_o,
	output logic [2*COORD_WIDTH:0]        sxy_o,
	output logic [2*COORD_WIDTH+1:0]      s3_o
);
	localparam int CW = COORD_WIDTH;
	localparam int LO = (CW + 1) / 2;
	localparam int HI = CW - LO;
	localparam int SQ = 2 * CW;

	logic [CW-1:0]        crd_in [3];
	logic [CW-1:0]        crd_s1 [3];
	logic [CW-1:0]        crd_s2 [3];
	logic [CW-1:0]        crd_s3 [3];
	logic [CW-1:0]        crd_s4 [3];
	logic [CW-1:0]        mag_s1 [3];
	logic [2*LO-1:0]      pll_s2 [3];
	logic [LO+HI-1:0]     plh_s2 [3];
	logic [2*HI-1:0]      phh_s2 [3];
	logic [SQ-1:0]        sq_s3  [3];
	logic [SQ:0]          sxy_s4;
	logic [SQ+1:0]        s3_s4;
	logic                 vld_s1, vld_s2, vld_s3, vld_s4;
	logic                 zero_s1, zero_s2, zero_s3, zero_s4;

	assign crd_in[0] = x_i;
	assign crd_in[1] = y_i;
	assign crd_in[2] = z_i;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s1 <= zero_i;
			zero_s2 <= zero_s1;
			zero_s3 <= zero_s2;
			zero_s4 <= zero_s3;
			for (int k = 0; k < 3; k++) begin
				crd_s1[k] <= crd_in[k];
				crd_s2[k] <= crd_s1[k];
				crd_s3[k] <= crd_s2[k];
				crd_s4[k] <= crd_s3[k];
				mag_s1[k] <= crd_in[k][CW-1] ? (CW'(0) - crd_in[k]) : crd_in[k];
				pll_s2[k] <= (2*LO)'(mag_s1[k][LO-1:0]) * (2*LO)'(mag_s1[k][LO-1:0]);
				plh_s2[k] <= (LO+HI)'(mag_s1[k][LO-1:0]) * (LO+HI)'(mag_s1[k][CW-1:LO]);
				phh_s2[k] <= (2*HI)'(mag_s1[k][CW-1:LO]) * (2*HI)'(mag_s1[k][CW-1:LO]);
				sq_s3[k]  <= (SQ'(phh_s2[k]) << (2*LO)) + (SQ'(plh_s2[k]) << (LO+1))
					+ SQ'(pll_s2[k]);
			end
			sxy_s4 <= (SQ+1)'(sq_s3[0]) + (SQ+1)'(sq_s3[1]);
			s3_s4  <= (SQ+2)'(sq_s3[0]) + (SQ+2)'(sq_s3[1]) + (SQ+2)'(sq_s3[2]);
		end
	end

	assign vld_o  = vld_s4;
	assign zero_o = zero_s4;
	assign x_o    = crd_s4[0];
	assign y_o    = crd_s4[1];
	assign z_o    = crd_s4[2];
	assign sxy_o  = sxy_s4;
	assign s3_o   = s3_s4;
endmodule

[design/c2s_isqrt.sv]
// Pipelined restoring integer square root, one root bit per stage, two lanes.
// Depends on c2s_pkg for the lane count; a sideband word travels with each beat.
module c2s_isqrt import c2s_pkg::*; #(
	parameter int ROOT_W = COORD_WIDTH_DEF + FRAC_RHO + 1,
	parameter int SIDE_W = 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  vld_i,
	input  logic [2*ROOT_W-1:0]   op_i [NUM_LANES],
	input  logic [SIDE_W-1:0]     side_i,
	output logic                  vld_o,
	output logic [ROOT_W-1:0]     root_o [NUM_LANES],
	output logic [SIDE_W-1:0]     side_o
);
	localparam int OP_W  = 2 * ROOT_W;
	localparam int REM_W = ROOT_W + 2;

	logic              vld_s  [ROOT_W];
	logic [SIDE_W-1:0] side_s [ROOT_W];
	logic [OP_W-1:0]   op_s   [ROOT_W][NUM_LANES];
	logic [REM_W-1:0]  rem_s  [ROOT_W][NUM_LANES];
	logic [ROOT_W-1:0] root_s [ROOT_W][NUM_LANES];

	for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
		logic              vld_in;
		logic [SIDE_W-1:0] side_in;

		if (j == 0) begin : g_first
			assign vld_in  = vld_i;
			assign side_in = side_i;
		end else begin : g_next
			assign vld_in  = vld_s[j-1];
			assign side_in = side_s[j-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (en) begin
				vld_s[j] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[j] <= side_in;
			end
		end

		for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
			logic [OP_W-1:0]   op_in;
			logic [REM_W-1:0]  rem_in;
			logic [ROOT_W-1:0] root_in;
			logic [REM_W-1:0]  tmp;
			logic [REM_W:0]    diff;

			if (j == 0) begin : g_first
				assign op_in   = op_i[l];
				assign rem_in  = '0;
				assign root_in = '0;
			end else begin : g_next
				assign op_in   = op_s[j-1][l];
				assign rem_in  = rem_s[j-1][l];
				assign root_in = root_s[j-1][l];
			end

			assign tmp  = {rem_in[ROOT_W-1:0], op_in[OP_W-1 -: 2]};
			assign diff = {1'b0, tmp} - {1'b0, root_in, 2'b01};

			always_ff @(posedge clk) begin
				if (en) begin
					op_s[j][l] <= op_in << 2;
					if (!diff[REM_W]) begin
						rem_s[j][l]  <= diff[REM_W-1:0];
						root_s[j][l] <= {root_in[ROOT_W-2:0], 1'b1};
					end else begin
						rem_s[j][l]  <= tmp;
						root_s[j][l] <= {root_in[ROOT_W-2:0], 1'b0};
					end
				end
			end

			assign root_o[l] = root_s[ROOT_W-1][l];
		end
	end

	assign vld_o  = vld_s[ROOT_W-1];
	assign side_o = side_s[ROOT_W-1];
endmodule

[design/c2s_cordic.sv]
// Pipelined vectoring CORDIC, two lanes: axis check, max, six shift stages, 32 rotations.
// Depends on c2s_pkg for the lane type, the stage functions and the arctangent table.
module c2s_cordic import c2s_pkg::*; #(
	parameter int SIDE_W = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                vld_i,
	input  logic [CORDIC_W-1:0] ys_i [NUM_LANES],
	input  logic [CORDIC_W-1:0] xs_i [NUM_LANES],
	input  logic [SIDE_W-1:0]   side_i,
	output logic                vld_o,
	output logic [TURN_W-1:0]   ang_o [NUM_LANES],
	output logic [SIDE_W-1:0]   side_o
);
	logic              vld_s  [CORDIC_LAT];
	logic [SIDE_W-1:0] side_s [CORDIC_LAT];
	c2s_lane_t         lane_s [CORDIC_LAT][NUM_LANES];

	for (genvar j = 0; j < CORDIC_LAT; j++) begin : g_stage
		logic              vld_in;
		logic [SIDE_W-1:0] side_in;

		if (j == 0) begin : g_first
			assign vld_in  = vld_i;
			assign side_in = side_i;
		end else begin : g_next
			assign vld_in  = vld_s[j-1];
			assign side_in = side_s[j-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (en) begin
				vld_s[j] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[j] <= side_in;
			end
		end

		for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
			c2s_lane_t nxt;

			if (j == 0) begin : g_pre
				assign nxt = c2s_pre(ys_i[l], xs_i[l]);
			end else if (j == 1) begin : g_max
				assign nxt = c2s_max(lane_s[j-1][l]);
			end else if (j < 2 + NORM_STEPS) begin : g_norm
				assign nxt = c2s_norm(lane_s[j-1][l], 32 >> (j - 2));
			end else begin : g_rot
				assign nxt = c2s_iter(lane_s[j-1][l], j - 2 - NORM_STEPS,
					ATAN_TAB[j-2-NORM_STEPS]);
			end

			always_ff @(posedge clk) begin
				if (en) begin
					lane_s[j][l] <= nxt;
				end
			end
		end
	end

	for (genvar l = 0; l < NUM_LANES; l++) begin : g_out
		assign ang_o[l] = lane_s[CORDIC_LAT-1][l].spc ? lane_s[CORDIC_LAT-1][l].fix
			: lane_s[CORDIC_LAT-1][l].acc;
	end

	assign vld_o  = vld_s[CORDIC_LAT-1];
	assign side_o = side_s[CORDIC_LAT-1];
endmodule

[design/cartesian_to_spherical.sv]
// Top level of the Cartesian to spherical converter: input register, squares, roots,
// CORDIC and output register. Depends on c2s_pkg, the two channel interfaces,
// c2s_square, c2s_isqrt and c2s_cordic.
//
//   channel   dir   beat contents
//   point     in    x_coord, y_coord, z_coord (signed, COORD_WIDTH each)
//   sphere    out   radius, polar_angle, azimuth_angle, zero_vector
//
// A point is taken in every cycle in which the output register is empty or is being
// drained, so the sustained rate is one beat per clock while the sink keeps ready high.
// The pipeline depth is set mainly by the one-bit-per-stage square root of the
// xy-plane length (COORD_WIDTH + 13 stages) followed by the 40-stage CORDIC.
// Reset clears only the valid bits of all stages; no clearing pass is needed.
// When the sink holds ready low with a result waiting, the whole pipeline freezes in
// place and point.ready drops in the same cycle, so no beat is lost or repeated.
module cartesian_to_spherical import c2s_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
	input logic          clk,
	input logic          arst_n,
	c2s_point_if.sink    point,
	c2s_sphere_if.source sphere
);
	localparam int CW     = COORD_WIDTH;
	localparam int AW     = ANGLE_WIDTH;
	localparam int ROOT_W = CW + FRAC_RHO + 1;
	localparam int OP_W   = 2 * ROOT_W;
	localparam int ISQ_SIDE_W = 3 * CW + 1;
	localparam int COR_SIDE_W = CW + 1;

	// Global advance: every stage moves when the output register can take a beat.
	logic en;

	// Input register.
	logic                 vld_s1;
	logic signed [CW-1:0] x_s1, y_s1, z_s1;
	logic                 zero_s1;

	// After the sum of squares.
	logic                 vld_sq, zero_sq;
	logic signed [CW-1:0] x_sq, y_sq, z_sq;
	logic [2*CW:0]        sxy_sq;
	logic [2*CW+1:0]      s3_sq;

	// After the square roots.
	logic                  vld_iq;
	logic [OP_W-1:0]       op_sq  [NUM_LANES];
	logic [ROOT_W-1:0]     root_iq [NUM_LANES];
	logic [ISQ_SIDE_W-1:0] side_iq;
	logic                  zero_iq;
	logic signed [CW-1:0]  x_iq, y_iq, z_iq;

	// After the CORDIC.
	logic [CORDIC_W-1:0]   ys_iq [NUM_LANES];
	logic [CORDIC_W-1:0]   xs_iq [NUM_LANES];
	logic                  vld_cq;
	logic [TURN_W-1:0]     ang_cq [NUM_LANES];
	logic [COR_SIDE_W-1:0] side_cq;
	logic [TURN_W-1:0]     pol_clamp;
	logic [AW-1:0]         pol_scaled, az_scaled;

	// Output register.
	logic          out_vld_q;
	logic [CW-1:0] radius_q;
	logic [AW-1:0] polar_q, azimuth_q;
	logic          zero_q;

	assign en          = !out_vld_q || sphere.ready;
	assign point.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= point.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= point.x_coord;
			y_s1 <= point.y_coord;
			z_s1 <= point.z_coord;
		end
	end

	assign zero_s1 = (x_s1 == '0) && (y_s1 == '0) && (z_s1 == '0);

	c2s_square #(
		.COORD_WIDTH(CW)
	) u_square (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (vld_s1),
		.zero_i (zero_s1),
		.x_i    (x_s1),
		.y_i    (y_s1),
		.z_i    (z_s1),
		.vld_o  (vld_sq),
		.zero_o (zero_sq),
		.x_o    (x_sq),
		.y_o    (y_sq),
		.z_o    (z_sq),
		.sxy_o  (sxy_sq),
		.s3_o   (s3_sq)
	);

	// Both roots carry FRAC_RHO extra fraction bits: the xy length feeds the polar
	// CORDIC at that scale, and the radius drops them again, which keeps the floor.
	assign op_sq[LANE_POL] = OP_W'(sxy_sq) << (2 * FRAC_RHO);
	assign op_sq[LANE_AZ]  = OP_W'(s3_sq) << (2 * FRAC_RHO);

	c2s_isqrt #(
		.ROOT_W (ROOT_W),
		.SIDE_W (ISQ_SIDE_W)
	) u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (vld_sq),
		.op_i   (op_sq),
		.side_i ({zero_sq, x_sq, y_sq, z_sq}),
		.vld_o  (vld_iq),
		.root_o (root_iq),
		.side_o (side_iq)
	);

	assign {zero_iq, x_iq, y_iq, z_iq} = side_iq;

	// Polar lane works on atan2(rho, z), with z brought to the scale of rho.
	// The azimuth lane works on atan2(y, x).
	assign ys_iq[LANE_POL] = CORDIC_W'(root_iq[LANE_POL]);
	assign xs_iq[LANE_POL] = CORDIC_W'(z_iq) << FRAC_RHO;
	assign ys_iq[LANE_AZ]  = CORDIC_W'(y_iq);
	assign xs_iq[LANE_AZ]  = CORDIC_W'(x_iq);

	c2s_cordic #(
		.SIDE_W (COR_SIDE_W)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (vld_iq),
		.ys_i   (ys_iq),
		.xs_i   (xs_iq),
		.side_i ({zero_iq, root_iq[LANE_AZ][FRAC_RHO +: CW]}),
		.vld_o  (vld_cq),
		.ang_o  (ang_cq),
		.side_o (side_cq)
	);

	// A polar result that rounding pushed past half a turn is folded back: into zero
	// when it landed in the last quarter, onto half a turn otherwise.
	always_comb begin
		pol_clamp = ang_cq[LANE_POL];
		if (ang_cq[LANE_POL] > TURN_HALF) begin
			pol_clamp = (ang_cq[LANE_POL] >= TURN_3Q) ? TURN_ZERO : TURN_HALF;
		end
	end

	// Angles leave the CORDIC in 32-bit turns; narrower outputs round to nearest,
	// wider ones append zeros.
	if (AW >= TURN_W) begin : g_wide
		assign pol_scaled = AW'(pol_clamp) << (AW - TURN_W);
		assign az_scaled  = AW'(ang_cq[LANE_AZ]) << (AW - TURN_W);
	end else begin : g_narrow
		localparam int SH = TURN_W - AW;
		logic [TURN_W:0] pol_rnd, az_rnd;
		assign pol_rnd    = {1'b0, pol_clamp} + ((TURN_W+1)'(1) << (SH - 1));
		assign az_rnd     = {1'b0, ang_cq[LANE_AZ]} + ((TURN_W+1)'(1) << (SH - 1));
		assign pol_scaled = pol_rnd[TURN_W-1:SH];
		assign az_scaled  = az_rnd[TURN_W-1:SH];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= vld_cq;
		end
	end

	// The zero vector reports both angles as zero.
	always_ff @(posedge clk) begin
		if (en) begin
			zero_q    <= side_cq[CW];
			radius_q  <= side_cq[CW-1:0];
			polar_q   <= side_cq[CW] ? '0 : pol_scaled;
			azimuth_q <= side_cq[CW] ? '0 : az_scaled;
		end
	end

	assign sphere.valid         = out_vld_q;
	assign sphere.radius        = radius_q;
	assign sphere.polar_angle   = polar_q;
	assign sphere.azimuth_angle = azimuth_q;
	assign sphere.zero_vector   = zero_q;

`ifndef SYNTHESIS
	localparam logic [AW-1:0] POLAR_MAX = AW'(1) << (AW - 1);

	a_zero_beat: assert property (@(posedge clk) disable iff (!arst_n)
		sphere.valid && sphere.zero_vector |->
			(sphere.radius == '0) && (sphere.polar_angle == '0)
			&& (sphere.azimuth_angle == '0))
		else $error("zero vector beat with nonzero radius or angle");

	a_polar_range: assert property (@(posedge clk) disable iff (!arst_n)
		sphere.valid |-> sphere.polar_angle <= POLAR_MAX)
		else $error("polar angle above half a turn");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!point.ready |-> sphere.valid && !sphere.ready)
		else $error("input stalled without a waiting result");

	a_hold_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		sphere.valid && !sphere.ready |=> sphere.valid && $stable(radius_q))
		else $error("waiting result changed under stall");
`endif
endmodule
